@@ rtl/tap_pkg.sv @@
// Package with the shared types, constants and transition tables of the automaton player.
`timescale 1ns / 1ps

package tap_pkg;

    // Table dimensions and queue defaults.
    localparam int NUM_STATES      = 32;
    localparam int NUM_TRANSITIONS = 80;
    localparam int QUEUE_DEPTH_DEF = 16;

    // Field widths.
    localparam int STATE_W = 5;
    localparam int EVENT_W = 5;
    localparam int LEVEL_W = 5;
    localparam int LINK_W  = $clog2(NUM_TRANSITIONS + 1);
    localparam int TIDX_W  = $clog2(NUM_TRANSITIONS);
    localparam int SIDX_W  = $clog2(NUM_STATES);

    localparam logic [STATE_W-1:0] INITIAL_STATE_RST = 5'd30;

    // Operation codes of an input request.
    localparam logic OP_ENQUEUE = 1'b0;
    localparam logic OP_STEP    = 1'b1;

    typedef struct packed {
        logic               op;
        logic [EVENT_W-1:0] event_code;
        logic               force_initial;
    } in_t;

    typedef struct packed {
        logic [STATE_W-1:0] automaton_state;
        logic [EVENT_W-1:0] event_used;
        logic               from_queue;
        logic               fired;
        logic               deadlock;
        logic               overflow;
        logic [LEVEL_W-1:0] queue_level;
    } out_t;

    // Queue status handed from the event queue to the controller.
    typedef struct packed {
        logic full;
        logic empty;
    } q_flags_t;

    // Event carried by each transition.
    localparam logic [EVENT_W-1:0] TR_EVENT [NUM_TRANSITIONS] = '{
        5'd16, 5'd16, 5'd7,  5'd6,  5'd5,  5'd3,  5'd16, 5'd3,  5'd0,  5'd5,
        5'd1,  5'd15, 5'd15, 5'd15, 5'd15, 5'd15, 5'd15, 5'd14, 5'd14, 5'd14,
        5'd14, 5'd14, 5'd14, 5'd7,  5'd6,  5'd4,  5'd2,  5'd0,  5'd1,  5'd16,
        5'd16, 5'd16, 5'd16, 5'd16, 5'd0,  5'd7,  5'd4,  5'd6,  5'd1,  5'd2,
        5'd1,  5'd6,  5'd2,  5'd4,  5'd7,  5'd0,  5'd16, 5'd16, 5'd16, 5'd2,
        5'd1,  5'd0,  5'd4,  5'd4,  5'd1,  5'd0,  5'd2,  5'd3,  5'd1,  5'd0,
        5'd4,  5'd7,  5'd5,  5'd1,  5'd0,  5'd2,  5'd6,  5'd8,  5'd9,  5'd10,
        5'd11, 5'd12, 5'd13, 5'd16, 5'd7,  5'd0,  5'd4,  5'd1,  5'd2,  5'd6
    };

    // Target state of each transition.
    localparam logic [STATE_W-1:0] TR_TARGET [NUM_TRANSITIONS] = '{
        5'd20, 5'd19, 5'd25, 5'd24, 5'd28, 5'd29, 5'd2,  5'd29, 5'd0,  5'd28,
        5'd1,  5'd10, 5'd11, 5'd12, 5'd13, 5'd14, 5'd15, 5'd16, 5'd26, 5'd27,
        5'd17, 5'd18, 5'd23, 5'd27, 5'd26, 5'd29, 5'd28, 5'd0,  5'd1,  5'd31,
        5'd21, 5'd22, 5'd16, 5'd16, 5'd0,  5'd27, 5'd29, 5'd26, 5'd1,  5'd28,
        5'd1,  5'd26, 5'd28, 5'd29, 5'd27, 5'd0,  5'd16, 5'd3,  5'd3,  5'd28,
        5'd1,  5'd0,  5'd29, 5'd29, 5'd1,  5'd0,  5'd28, 5'd26, 5'd1,  5'd0,
        5'd2,  5'd27, 5'd27, 5'd1,  5'd0,  5'd2,  5'd26, 5'd4,  5'd5,  5'd6,
        5'd7,  5'd8,  5'd9,  5'd16, 5'd27, 5'd0,  5'd29, 5'd1,  5'd28, 5'd26
    };

    // First transition of each state's list, one-based; zero means no list.
    localparam logic [LINK_W-1:0] LIST_HEAD [NUM_STATES] = '{
        7'd1,  7'd2,  7'd7,  7'd11, 7'd12, 7'd13, 7'd14, 7'd15,
        7'd16, 7'd17, 7'd18, 7'd19, 7'd20, 7'd21, 7'd22, 7'd23,
        7'd30, 7'd31, 7'd32, 7'd33, 7'd34, 7'd40, 7'd46, 7'd47,
        7'd48, 7'd49, 7'd53, 7'd57, 7'd62, 7'd67, 7'd73, 7'd80
    };

    // Next transition in the same list, one-based; zero ends the list.
    localparam logic [LINK_W-1:0] LIST_LINK [NUM_TRANSITIONS] = '{
        7'd0,  7'd0,  7'd0,  7'd3,  7'd4,  7'd5,  7'd6,  7'd0,  7'd8,  7'd9,
        7'd10, 7'd0,  7'd0,  7'd0,  7'd0,  7'd0,  7'd0,  7'd0,  7'd0,  7'd0,
        7'd0,  7'd0,  7'd0,  7'd0,  7'd24, 7'd25, 7'd26, 7'd27, 7'd28, 7'd29,
        7'd0,  7'd0,  7'd0,  7'd0,  7'd0,  7'd35, 7'd36, 7'd37, 7'd38, 7'd39,
        7'd0,  7'd41, 7'd42, 7'd43, 7'd44, 7'd45, 7'd0,  7'd0,  7'd0,  7'd0,
        7'd50, 7'd51, 7'd52, 7'd0,  7'd54, 7'd55, 7'd56, 7'd0,  7'd58, 7'd59,
        7'd60, 7'd61, 7'd0,  7'd63, 7'd64, 7'd65, 7'd66, 7'd0,  7'd68, 7'd69,
        7'd70, 7'd71, 7'd72, 7'd0,  7'd74, 7'd75, 7'd76, 7'd77, 7'd78, 7'd79
    };

endpackage

@@ rtl/tap_queue.sv @@
// Event queue of the automaton player: a circular buffer in a synchronous memory.
`timescale 1ns / 1ps

module tap_queue #(
    parameter int DEPTH = tap_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            push,
    input  logic [tap_pkg::EVENT_W-1:0]     push_data,
    input  logic                            pop,
    output logic [tap_pkg::EVENT_W-1:0]     rd_data,
    output logic [$clog2(DEPTH+1)-1:0]      count,
    output tap_pkg::q_flags_t               flags
);
    import tap_pkg::*;

    localparam int IW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic [EVENT_W-1:0] mem [DEPTH];
    logic [EVENT_W-1:0] rd_data_reg;
    logic [IW-1:0]      head_reg, head_next;
    logic [CW-1:0]      count_reg, count_next;
    logic [CW:0]        tail_sum;
    logic [IW-1:0]      tail;
    logic               do_push, do_pop;

    assign flags.full  = (count_reg == CW'(DEPTH));
    assign flags.empty = (count_reg == '0);
    assign do_push     = push && !flags.full;
    assign do_pop      = pop && !flags.empty;

    // The write slot lies count entries past the head, wrapped once.
    always_comb begin
        tail_sum = (CW+1)'(head_reg) + (CW+1)'(count_reg);
        if (tail_sum >= (CW+1)'(DEPTH)) begin
            tail = IW'(tail_sum - (CW+1)'(DEPTH));
        end else begin
            tail = IW'(tail_sum);
        end
    end

    // Pointer and fill count updates.
    always_comb begin
        head_next  = head_reg;
        count_next = count_reg;
        if (do_pop) begin
            head_next = (head_reg == IW'(DEPTH - 1)) ? '0 : head_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg  <= '0;
            count_reg <= '0;
        end else begin
            head_reg  <= head_next;
            count_reg <= count_next;
        end
    end

    // Memory write port and registered read port.
    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem[tail] <= push_data;
        end
        if (do_pop) begin
            rd_data_reg <= mem[head_reg];
        end
    end

    assign rd_data = rd_data_reg;
    assign count   = count_reg;

endmodule

@@ rtl/table_automaton_player.sv @@
// Flow: an enqueue request goes from IDLE through DONE into the output register, a step request
// through FETCH, then WALK over its transition list entries (at most 7 with these tables), then DONE.
// One request is in work at a time; the next is taken once the sequencer is back in IDLE, while
// a held result may still wait in the output register. A full output register stalls the
// sequencer until the sink takes the result.
// Reset is synchronous, active low: state and config return to 30, the queue empties.
`timescale 1ns / 1ps

module table_automaton_player #(
    parameter int QUEUE_DEPTH = tap_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [tap_pkg::STATE_W-1:0]    cfg_data,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  tap_pkg::in_t                   s_data,
    output logic                           m_valid,
    input  logic                           m_ready,
    output tap_pkg::out_t                  m_data
);
    import tap_pkg::*;

    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_FETCH = 4'b0010,
        ST_WALK  = 4'b0100,
        ST_DONE  = 4'b1000
    } state_t;

    state_t             state_reg, state_next;
    logic [STATE_W-1:0] init_reg;
    logic [STATE_W-1:0] node_reg, node_next;
    logic [EVENT_W-1:0] ev_reg, ev_next;
    logic [EVENT_W-1:0] code_reg, code_next;
    logic               fq_reg, fq_next;
    logic               fired_reg, fired_next;
    logic               dl_reg, dl_next;
    logic               ovf_reg, ovf_next;
    logic [LINK_W-1:0]  k_reg, k_next;
    logic               m_valid_reg;
    out_t               m_data_reg;

    logic               accept;
    logic               q_push, q_pop;
    logic [EVENT_W-1:0] q_rd_data;
    logic [CW-1:0]      q_count;
    q_flags_t           q_flags;
    logic [EVENT_W-1:0] fetch_ev;
    logic [LINK_W-1:0]  head_k;
    logic [TIDX_W-1:0]  tidx;
    logic               out_free;

    // Configuration register, always writable.
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            init_reg <= INITIAL_STATE_RST;
        end else if (cfg_valid && cfg_ready) begin
            init_reg <= cfg_data;
        end
    end

    tap_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_data (s_data.event_code),
        .pop       (q_pop),
        .rd_data   (q_rd_data),
        .count     (q_count),
        .flags     (q_flags)
    );

    assign s_ready  = (state_reg == ST_IDLE);
    assign accept   = s_valid && s_ready;
    assign q_push   = accept && (s_data.op == OP_ENQUEUE) && !q_flags.full;
    assign q_pop    = accept && (s_data.op == OP_STEP) && !q_flags.empty;
    assign out_free = !m_valid_reg || m_ready;

    // ROM lookups for the list head and the current transition entry.
    assign fetch_ev = fq_reg ? q_rd_data : code_reg;
    assign head_k   = LIST_HEAD[node_reg[SIDX_W-1:0]];
    assign tidx     = TIDX_W'(k_reg - 1'b1);

    // Request sequencer: accept, fetch event and list head, walk the list, deliver.
    always_comb begin
        state_next = state_reg;
        node_next  = node_reg;
        ev_next    = ev_reg;
        code_next  = code_reg;
        fq_next    = fq_reg;
        fired_next = fired_reg;
        dl_next    = dl_reg;
        ovf_next   = ovf_reg;
        k_next     = k_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    fired_next = 1'b0;
                    dl_next    = 1'b0;
                    ovf_next   = 1'b0;
                    ev_next    = '0;
                    fq_next    = 1'b0;
                    code_next  = s_data.event_code;
                    if (s_data.op == OP_ENQUEUE) begin
                        ovf_next   = q_flags.full;
                        state_next = ST_DONE;
                    end else begin
                        if (s_data.force_initial) begin
                            node_next = init_reg;
                        end
                        fq_next    = !q_flags.empty;
                        state_next = ST_FETCH;
                    end
                end
            end
            ST_FETCH: begin
                ev_next = fetch_ev;
                k_next  = head_k;
                if (head_k == '0) begin
                    dl_next    = 1'b1;
                    state_next = ST_DONE;
                end else begin
                    state_next = ST_WALK;
                end
            end
            ST_WALK: begin
                if (k_reg == '0 || k_reg > LINK_W'(NUM_TRANSITIONS)) begin
                    state_next = ST_DONE;
                end else if (TR_EVENT[tidx] == ev_reg) begin
                    node_next  = TR_TARGET[tidx];
                    fired_next = 1'b1;
                    state_next = ST_DONE;
                end else begin
                    k_next = LIST_LINK[tidx];
                    if (LIST_LINK[tidx] == '0) begin
                        state_next = ST_DONE;
                    end
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            node_reg  <= INITIAL_STATE_RST;
        end else begin
            state_reg <= state_next;
            node_reg  <= node_next;
        end
    end

    always_ff @(posedge aclk) begin
        ev_reg    <= ev_next;
        code_reg  <= code_next;
        fq_reg    <= fq_next;
        fired_reg <= fired_next;
        dl_reg    <= dl_next;
        ovf_reg   <= ovf_next;
        k_reg     <= k_next;
    end

    // Output register: loaded when the result is done and the slot is free.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (state_reg == ST_DONE && out_free) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == ST_DONE && out_free) begin
            m_data_reg.automaton_state <= node_reg;
            m_data_reg.event_used      <= ev_reg;
            m_data_reg.from_queue      <= fq_reg;
            m_data_reg.fired           <= fired_reg;
            m_data_reg.deadlock        <= dl_reg;
            m_data_reg.overflow        <= ovf_reg;
            m_data_reg.queue_level     <= LEVEL_W'(q_count);
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // The queue never holds more events than it has entries.
    assert property (@(posedge aclk) disable iff (!aresetn)
        q_count <= CW'(QUEUE_DEPTH))
        else $error("Queue fill count exceeds its depth.");

    // A dropped event is only reported while the queue is full.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DONE && ovf_reg) |-> q_flags.full)
        else $error("Overflow reported with room left in the queue.");

    // A step that takes a queued event removes exactly one entry.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && s_data.op == OP_STEP && !q_flags.empty)
        |=> (q_count == $past(q_count) - 1'b1))
        else $error("Step did not pop one event from the queue.");

    // A transition never fires from a state without a list.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> !(m_data_reg.fired && m_data_reg.deadlock))
        else $error("Result marks both fired and deadlock.");

    // The list walk only runs on a valid one-based transition index.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_FETCH && head_k != '0) |=> (k_reg != '0))
        else $error("List walk started without a transition index.");

endmodule

@@ dv/tap_automaton_checker.sv @@
// Checker that predicts and compares every result of the automaton player.
`timescale 1ns / 1ps

module tap_automaton_checker (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        cfg_valid,
    input  logic                        cfg_ready,
    input  logic [tap_pkg::STATE_W-1:0] cfg_data,
    input  logic                        s_valid,
    input  logic                        s_ready,
    input  tap_pkg::in_t                s_data,
    input  logic                        m_valid,
    input  logic                        m_ready,
    input  tap_pkg::out_t               m_data,
    output int                          fail_cnt,
    output int                          pending_cnt
);
    import tap_pkg::*;

    localparam int QDEPTH = QUEUE_DEPTH_DEF;

    // Shadow copy of the player: configuration, current node and event queue.
    logic [STATE_W-1:0] start_state;
    logic [STATE_W-1:0] node;
    logic [EVENT_W-1:0] sensor_fifo [QDEPTH];
    int                 fifo_head;
    int                 fifo_level;

    out_t player_outputs [$];
    out_t want;

    // Apply one request to the shadow player and return the result it should give.
    function automatic out_t play_request(in_t req);
        out_t               res;
        logic [EVENT_W-1:0] ev;
        logic [LINK_W-1:0]  link;
        int                 idx;
        res = '0;
        if (req.op == OP_ENQUEUE) begin
            if (fifo_level >= QDEPTH) begin
                res.overflow = 1'b1;
            end else begin
                sensor_fifo[(fifo_head + fifo_level) % QDEPTH] = req.event_code;
                fifo_level++;
            end
        end else begin
            // A low-battery return reloads the start state before the lookup.
            if (req.force_initial) begin
                node = start_state;
            end
            if (fifo_level > 0) begin
                ev = sensor_fifo[fifo_head];
                fifo_head = (fifo_head + 1) % QDEPTH;
                fifo_level--;
                res.from_queue = 1'b1;
            end else begin
                ev = req.event_code;
            end
            res.event_used = ev;
            // Walk the node's transition list and take the first matching event.
            link = (node < NUM_STATES) ? LIST_HEAD[node] : '0;
            if (link == 0) begin
                res.deadlock = 1'b1;
            end else begin
                for (int n = 0; n < NUM_TRANSITIONS; n++) begin
                    if (link == 0 || link > NUM_TRANSITIONS) begin
                        break;
                    end
                    idx = int'(link) - 1;
                    if (TR_EVENT[idx] == ev) begin
                        node = TR_TARGET[idx];
                        res.fired = 1'b1;
                        break;
                    end
                    link = LIST_LINK[idx];
                end
            end
        end
        res.automaton_state = node;
        res.queue_level = LEVEL_W'(fifo_level);
        return res;
    endfunction

    task automatic check_field(string name, int want_v, int got_v);
        if (want_v != got_v) begin
            $error("%s mismatch: expected %0d, actual %0d", name, want_v, got_v);
            fail_cnt++;
        end
    endtask

    // Track configuration, predict on each request and compare each result.
    always @(posedge aclk) begin
        if (!aresetn) begin
            start_state = INITIAL_STATE_RST;
            node = INITIAL_STATE_RST;
            fifo_head = 0;
            fifo_level = 0;
            for (int i = 0; i < QDEPTH; i++) begin
                sensor_fifo[i] = '0;
            end
            player_outputs.delete();
            fail_cnt = 0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                start_state = cfg_data;
            end
            if (s_valid && s_ready) begin
                player_outputs.push_back(play_request(s_data));
            end
            if (m_valid && m_ready) begin
                if (player_outputs.size() == 0) begin
                    $error("result with no request outstanding: state %0d event %0d",
                           m_data.automaton_state, m_data.event_used);
                    fail_cnt++;
                end else begin
                    want = player_outputs.pop_front();
                    check_field("automaton_state", want.automaton_state,
                                m_data.automaton_state);
                    check_field("event_used", want.event_used, m_data.event_used);
                    check_field("from_queue", want.from_queue, m_data.from_queue);
                    check_field("fired", want.fired, m_data.fired);
                    check_field("deadlock", want.deadlock, m_data.deadlock);
                    check_field("overflow", want.overflow, m_data.overflow);
                    check_field("queue_level", want.queue_level, m_data.queue_level);
                end
            end
        end
        pending_cnt = player_outputs.size();
    end

endmodule

@@ dv/tb_table_automaton_player.sv @@
// Top of the automaton player testbench: clock, reset, requests and verdict.
`timescale 1ns / 1ps

module tb_table_automaton_player;
    import tap_pkg::*;

    localparam int STALL_LIMIT     = 2000;
    localparam int ITEMS_PER_PHASE = 175;
    localparam int NUM_PHASES      = 6;
    localparam int TAIL_CYCLES     = 16;

    logic               aclk      = 1'b0;
    logic               aresetn   = 1'b0;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic [STATE_W-1:0] cfg_data  = '0;
    logic               s_valid   = 1'b0;
    logic               s_ready;
    in_t                s_data    = '0;
    logic               m_valid;
    logic               m_ready   = 1'b0;
    out_t               m_data;

    int fail_cnt;
    int pending_cnt;
    int sent_cnt     = 0;
    int stall_cycles = 0;

    table_automaton_player u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    tap_automaton_checker u_checker (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_data    (cfg_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data),
        .fail_cnt    (fail_cnt),
        .pending_cnt (pending_cnt)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // Watchdog: end the run when no channel has moved for too long.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
        if (stall_cycles >= STALL_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // Offer one request after a random gap and hold it until it is taken.
    task automatic send_request(logic op, logic [EVENT_W-1:0] code, logic force_init);
        int   gap;
        in_t  req;
        req.op = op;
        req.event_code = code;
        req.force_initial = force_init;
        // Every fifth block of a hundred requests runs back to back.
        gap = ((sent_cnt / 100) % 5 == 2) ? 0 : $urandom_range(0, 9);
        @(negedge aclk);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data <= req;
        do @(posedge aclk); while (!s_ready);
        sent_cnt++;
    endtask

    // Random request: mostly defined events, sometimes codes that match nothing.
    task automatic send_random(int enq_pct);
        logic [EVENT_W-1:0] code;
        logic               op;
        code = ($urandom_range(0, 99) < 85) ? EVENT_W'($urandom_range(0, 16))
                                            : EVENT_W'($urandom_range(0, 31));
        op = ($urandom_range(0, 99) < enq_pct) ? OP_ENQUEUE : OP_STEP;
        send_request(op, code, $urandom_range(0, 99) < 10);
    endtask

    // Wait until every predicted result has come back, then let the block settle.
    task automatic drain_results();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (pending_cnt != 0) @(negedge aclk);
        repeat (TAIL_CYCLES) @(negedge aclk);
    endtask

    task automatic write_start_state(logic [STATE_W-1:0] value);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_data <= value;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // Result side: random back-pressure, quiet stretches, and one long hold-off.
    initial begin : result_sink
        int rx_count;
        int hold;
        rx_count = 0;
        forever begin
            if (rx_count == 400) begin
                hold = 150;
            end else if ((rx_count / 128) % 4 == 3) begin
                hold = 0;
            end else begin
                hold = $urandom_range(0, 9);
            end
            @(negedge aclk);
            if (hold > 0) begin
                m_ready <= 1'b0;
                repeat (hold) @(negedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
            rx_count++;
        end
    end

    // Request side: reset, directed cases, then random phases under different settings.
    initial begin : stimulus
        int                 enq_pct [NUM_PHASES];
        logic [STATE_W-1:0] start_val;
        enq_pct = '{30, 75, 20, 60, 45, 50};
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Steps with an empty queue, an unknown code and a forced return.
        send_request(OP_STEP, 5'd0, 1'b0);
        send_request(OP_STEP, 5'd16, 1'b0);
        send_request(OP_STEP, 5'd31, 1'b0);
        send_request(OP_STEP, 5'd7, 1'b1);
        // Fill the queue to the brim, then one more is dropped.
        send_request(OP_ENQUEUE, 5'd31, 1'b0);
        send_request(OP_ENQUEUE, 5'd0, 1'b0);
        send_request(OP_ENQUEUE, 5'd16, 1'b0);
        for (int i = 0; i < 13; i++) begin
            send_request(OP_ENQUEUE, EVENT_W'($urandom_range(0, 16)), 1'b0);
        end
        send_request(OP_ENQUEUE, 5'd5, 1'b1);
        // Steps now take their events from the queue.
        send_request(OP_STEP, 5'd1, 1'b1);
        send_request(OP_STEP, 5'd0, 1'b0);
        send_request(OP_ENQUEUE, 5'd2, 1'b0);
        send_request(OP_STEP, 5'd4, 1'b0);
        drain_results();

        for (int phase = 0; phase < NUM_PHASES; phase++) begin
            case (phase)
                0: start_val = '0;
                1: start_val = '1;
                4: start_val = INITIAL_STATE_RST;
                default: start_val = STATE_W'($urandom_range(0, 31));
            endcase
            write_start_state(start_val);
            // A forced return right away puts the new start state to use.
            send_request(OP_STEP, EVENT_W'($urandom_range(0, 16)), 1'b1);
            for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
                send_random(enq_pct[phase]);
            end
            drain_results();
        end

        if (fail_cnt == 0 && pending_cnt == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/tap_pkg.sv
rtl/tap_queue.sv
rtl/table_automaton_player.sv
dv/tap_automaton_checker.sv
dv/tb_table_automaton_player.sv
